@@ design/cqs_pkg.sv @@
package cqs_pkg;

   // Fixed point format and datapath widths
   localparam int FRAC_BITS  = 16;
   localparam int DATA_W     = 32;
   localparam int RAD_W      = 64;
   localparam int SQRT_STEPS = RAD_W / 2;
   localparam int SQ_REM_W   = DATA_W + 2;
   localparam int DIV_W      = DATA_W + FRAC_BITS;
   localparam int DIV_REM_W  = DATA_W + 2;

   localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
   localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

   typedef struct packed {
      logic signed [DATA_W-1:0] coef_a_re;
      logic signed [DATA_W-1:0] coef_a_im;
      logic signed [DATA_W-1:0] coef_b_re;
      logic signed [DATA_W-1:0] coef_b_im;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] root1_re;
      logic signed [DATA_W-1:0] root1_im;
      logic signed [DATA_W-1:0] root2_re;
      logic signed [DATA_W-1:0] root2_im;
      logic                     overflow;
   } rsp_type;

   // Sideband that travels with an item along the pipeline.
   // p/q hold b until the discriminant stage overwrites them.
   typedef struct packed {
      logic                     valid;
      logic                     b_zero;
      logic signed [DATA_W-1:0] a_re;
      logic signed [DATA_W-1:0] a_im;
      logic signed [DATA_W-1:0] c_re;
      logic signed [DATA_W-1:0] c_im;
      logic signed [DATA_W-1:0] p;
      logic signed [DATA_W-1:0] q;
      logic                     ovf;
      logic [DATA_W-1:0]        s;
   } side_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] val;
      logic                     ovf;
   } sat_type;

   // Clamp a wide signed value to 32 bits
   function automatic sat_type sat32(input logic signed [63:0] v);
      sat_type r;
      if (v > S32_MAX) begin
         r.val = DATA_W'(S32_MAX);
         r.ovf = 1'b1;
      end else if (v < S32_MIN) begin
         r.val = DATA_W'(S32_MIN);
         r.ovf = 1'b1;
      end else begin
         r.val = v[DATA_W-1:0];
         r.ovf = 1'b0;
      end
      return r;
   endfunction

endpackage

@@ design/cqs_sqrt_cell.sv @@
module cqs_sqrt_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic [cqs_pkg::SQ_REM_W-1:0] up_rem,
   input  logic [cqs_pkg::DATA_W-1:0]   up_root,
   input  logic [cqs_pkg::RAD_W-1:0]    up_rad,
   input  cqs_pkg::side_type            up_side,
   output logic [cqs_pkg::SQ_REM_W-1:0] dn_rem,
   output logic [cqs_pkg::DATA_W-1:0]   dn_root,
   output logic [cqs_pkg::RAD_W-1:0]    dn_rad,
   output cqs_pkg::side_type            dn_side
);
   import cqs_pkg::*;

   localparam int SH_W = SQ_REM_W + 2;

   logic [SH_W-1:0]     shifted;
   logic [SH_W-1:0]     trial;
   logic [SH_W-1:0]     diff;
   logic                fits;
   logic [SQ_REM_W-1:0] rem_in, rem_ff;
   logic [DATA_W-1:0]   root_in, root_ff;
   logic [RAD_W-1:0]    rad_in, rad_ff;
   side_type            side_ff;
   logic                valid_ff;

   // One root bit: bring down two radicand bits, try (4r+1)
   assign shifted = {up_rem, up_rad[RAD_W-1 -: 2]};
   assign trial   = {2'b00, up_root, 2'b01};
   assign diff    = shifted - trial;
   assign fits    = (shifted >= trial);
   assign rem_in  = fits ? diff[SQ_REM_W-1:0] : shifted[SQ_REM_W-1:0];
   assign root_in = {up_root[DATA_W-2:0], fits};
   assign rad_in  = {up_rad[RAD_W-3:0], 2'b00};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= up_side.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         rad_ff  <= rad_in;
         side_ff <= up_side;
      end
   end

   always_comb begin
      dn_side       = side_ff;
      dn_side.valid = valid_ff;
   end

   assign dn_rem  = rem_ff;
   assign dn_root = root_ff;
   assign dn_rad  = rad_ff;

endmodule

@@ design/cqs_div_cell.sv @@
module cqs_div_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic [cqs_pkg::DIV_REM_W-1:0] up_rem,
   input  logic [cqs_pkg::DIV_W-1:0]     up_nq,
   input  cqs_pkg::side_type             up_side,
   output logic [cqs_pkg::DIV_REM_W-1:0] dn_rem,
   output logic [cqs_pkg::DIV_W-1:0]     dn_nq,
   output cqs_pkg::side_type             dn_side
);
   import cqs_pkg::*;

   localparam int SH_W = DIV_REM_W + 1;

   logic [SH_W-1:0]      shifted;
   logic [SH_W-1:0]      divisor;
   logic [SH_W-1:0]      diff;
   logic                 fits;
   logic [DIV_REM_W-1:0] rem_in, rem_ff;
   logic [DIV_W-1:0]     nq_in, nq_ff;
   side_type             side_ff;
   logic                 valid_ff;

   // Restoring step: divisor is 2s; numerator bits leave on the left,
   // quotient bits enter on the right of the same word
   assign divisor = {{(SH_W-DATA_W-1){1'b0}}, up_side.s, 1'b0};
   assign shifted = {up_rem, up_nq[DIV_W-1]};
   assign diff    = shifted - divisor;
   assign fits    = (shifted >= divisor);
   assign rem_in  = fits ? diff[DIV_REM_W-1:0] : shifted[DIV_REM_W-1:0];
   assign nq_in   = {up_nq[DIV_W-2:0], fits};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= up_side.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         nq_ff   <= nq_in;
         side_ff <= up_side;
      end
   end

   always_comb begin
      dn_side       = side_ff;
      dn_side.valid = valid_ff;
   end

   assign dn_rem = rem_ff;
   assign dn_nq  = nq_ff;

endmodule

@@ design/complex_quadratic_solver.sv @@
// Coefficients and roots are signed fixed point, Q16.16 when FRAC_BITS is 16.
// Throughput: one item per cycle unless stalled; the two square roots are 32-cell
// chains, the quotient a (32 + FRAC_BITS)-cell chain, each cell one bit per cycle.
// A two-entry result queue decouples the sides; input stalls only when it is full.
// Reset (synchronous, active high) empties the pipeline and the queue.
module complex_quadratic_solver (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cqs_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cqs_pkg::rsp_type  rsp_data
);
   import cqs_pkg::*;

   localparam int TOP_ST = 7;

   logic                  en;
   logic [TOP_ST-1:0]     valid_ff;
   logic [1:0]            cnt_ff, cnt_in;
   rsp_type               out0_ff, out1_ff;
   logic                  push, pop;
   rsp_type               new_rsp;

   // Stage 1: c = floor(-a/2)
   logic signed [DATA_W:0] neg_a_re, neg_a_im;
   side_type               s1_in, s1_ff;

   // Stage 2: products
   side_type               s2_ff;
   logic signed [63:0]     prod_rr_ff, prod_ii_ff, prod_ri_ff;

   // Stage 3: discriminant
   logic signed [63:0]     re_wide, im_wide;
   sat_type                p_sat, q_sat;
   side_type               s3_in, s3_ff;

   // Stage 4/5: modulus squared
   logic [DATA_W-1:0]      mag_p4, mag_q4;
   side_type               s4_ff, s5_ff;
   logic [RAD_W-1:0]       pp_ff, qq_ff, sum_ff;

   // Square root chain A: modulus
   logic [SQ_REM_W-1:0]    a_rem  [0:SQRT_STEPS];
   logic [DATA_W-1:0]      a_root [0:SQRT_STEPS];
   logic [RAD_W-1:0]       a_rad  [0:SQRT_STEPS];
   side_type               a_side [0:SQRT_STEPS];

   // Prep between chains
   logic [DATA_W-1:0]      mag_pp;
   logic [DATA_W:0]        t_sum;
   side_type               prep_ff;
   logic [RAD_W-1:0]       rad2_ff;

   // Square root chain B: s
   logic [SQ_REM_W-1:0]    b_rem  [0:SQRT_STEPS];
   logic [DATA_W-1:0]      b_root [0:SQRT_STEPS];
   logic [RAD_W-1:0]       b_rad  [0:SQRT_STEPS];
   side_type               b_side [0:SQRT_STEPS];

   // Divider chain
   logic [DATA_W-1:0]      mag_qd;
   logic [DIV_REM_W-1:0]   d_rem  [0:DIV_W];
   logic [DIV_W-1:0]       d_nq   [0:DIV_W];
   side_type               d_side [0:DIV_W];

   // Final select and roots
   side_type               dv;
   logic signed [63:0]     quo_s, other_w;
   sat_type                oth_sat, s_sat;
   side_type               fin_in, fin_ff;
   logic signed [DATA_W-1:0] d_re_in, d_im_in, d_re_ff, d_im_ff;
   sat_type                r1r, r1i, r2r, r2i, na_re, na_im;

   assign en        = (cnt_ff != 2'd2);
   assign req_ready = en;

   // Valid shift for the stages held in this module
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff[0] <= req_valid;
         valid_ff[1] <= valid_ff[0];
         valid_ff[2] <= valid_ff[1];
         valid_ff[3] <= valid_ff[2];
         valid_ff[4] <= valid_ff[3];
         valid_ff[5] <= a_side[SQRT_STEPS].valid;
         valid_ff[6] <= d_side[DIV_W].valid;
      end
   end

   // Stage 1
   assign neg_a_re = -$signed({req_data.coef_a_re[DATA_W-1], req_data.coef_a_re});
   assign neg_a_im = -$signed({req_data.coef_a_im[DATA_W-1], req_data.coef_a_im});

   always_comb begin
      s1_in        = '0;
      s1_in.b_zero = (req_data.coef_b_re == '0) && (req_data.coef_b_im == '0);
      s1_in.a_re   = req_data.coef_a_re;
      s1_in.a_im   = req_data.coef_a_im;
      s1_in.c_re   = neg_a_re[DATA_W:1];
      s1_in.c_im   = neg_a_im[DATA_W:1];
      s1_in.p      = req_data.coef_b_re;
      s1_in.q      = req_data.coef_b_im;
   end

   // Stage 3 discriminant: c*c - b, floor shift, saturate
   assign re_wide = ((prod_rr_ff - prod_ii_ff) >>> FRAC_BITS) - 64'(s2_ff.p);
   assign im_wide = ((prod_ri_ff <<< 1) >>> FRAC_BITS) - 64'(s2_ff.q);
   assign p_sat   = sat32(re_wide);
   assign q_sat   = sat32(im_wide);

   always_comb begin
      s3_in     = s2_ff;
      s3_in.p   = p_sat.val;
      s3_in.q   = q_sat.val;
      s3_in.ovf = p_sat.ovf | q_sat.ovf;
   end

   assign mag_p4 = s3_ff.p[DATA_W-1] ? (~s3_ff.p + 1'b1) : s3_ff.p;
   assign mag_q4 = s3_ff.q[DATA_W-1] ? (~s3_ff.q + 1'b1) : s3_ff.q;

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff      <= s1_in;
         s2_ff      <= s1_ff;
         prod_rr_ff <= s1_ff.c_re * s1_ff.c_re;
         prod_ii_ff <= s1_ff.c_im * s1_ff.c_im;
         prod_ri_ff <= s1_ff.c_re * s1_ff.c_im;
         s3_ff      <= s3_in;
         s4_ff      <= s3_ff;
         pp_ff      <= 64'(mag_p4) * 64'(mag_p4);
         qq_ff      <= 64'(mag_q4) * 64'(mag_q4);
         s5_ff      <= s4_ff;
         sum_ff     <= pp_ff + qq_ff;
      end
   end

   // Chain A: m = isqrt(p^2 + q^2)
   assign a_rem[0]  = '0;
   assign a_root[0] = '0;
   assign a_rad[0]  = sum_ff;
   always_comb begin
      a_side[0]       = s5_ff;
      a_side[0].valid = valid_ff[4];
   end

   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt_a
      cqs_sqrt_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .up_rem  (a_rem[i]),
         .up_root (a_root[i]),
         .up_rad  (a_rad[i]),
         .up_side (a_side[i]),
         .dn_rem  (a_rem[i+1]),
         .dn_root (a_root[i+1]),
         .dn_rad  (a_rad[i+1]),
         .dn_side (a_side[i+1])
      );
   end

   // Prep: (m + |p|) << (FRAC_BITS-1); with q zero this equals |p| << FRAC_BITS
   assign mag_pp = a_side[SQRT_STEPS].p[DATA_W-1] ?
                   (~a_side[SQRT_STEPS].p + 1'b1) : a_side[SQRT_STEPS].p;
   assign t_sum  = {1'b0, a_root[SQRT_STEPS]} + {1'b0, mag_pp};

   always_ff @(posedge clock) begin
      if (en) begin
         prep_ff <= a_side[SQRT_STEPS];
         rad2_ff <= RAD_W'(t_sum) << (FRAC_BITS - 1);
      end
   end

   // Chain B: s
   assign b_rem[0]  = '0;
   assign b_root[0] = '0;
   assign b_rad[0]  = rad2_ff;
   always_comb begin
      b_side[0]       = prep_ff;
      b_side[0].valid = valid_ff[5];
   end

   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt_b
      cqs_sqrt_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .up_rem  (b_rem[i]),
         .up_root (b_root[i]),
         .up_rad  (b_rad[i]),
         .up_side (b_side[i]),
         .dn_rem  (b_rem[i+1]),
         .dn_root (b_root[i+1]),
         .dn_rad  (b_rad[i+1]),
         .dn_side (b_side[i+1])
      );
   end

   // Divider chain: |q| * 2^FRAC_BITS / (2s)
   assign mag_qd = b_side[SQRT_STEPS].q[DATA_W-1] ?
                   (~b_side[SQRT_STEPS].q + 1'b1) : b_side[SQRT_STEPS].q;
   assign d_rem[0] = '0;
   assign d_nq[0]  = {mag_qd, {FRAC_BITS{1'b0}}};
   always_comb begin
      d_side[0]   = b_side[SQRT_STEPS];
      d_side[0].s = b_root[SQRT_STEPS];
   end

   for (genvar i = 0; i < DIV_W; i++) begin : g_div
      cqs_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .up_rem  (d_rem[i]),
         .up_nq   (d_nq[i]),
         .up_side (d_side[i]),
         .dn_rem  (d_rem[i+1]),
         .dn_nq   (d_nq[i+1]),
         .dn_side (d_side[i+1])
      );
   end

   // Sign the quotient (zero when q is zero) and place it by the sign of p
   assign dv      = d_side[DIV_W];
   assign quo_s   = $signed(64'(d_nq[DIV_W]));
   assign other_w = (dv.q == '0) ? '0 : ((dv.q < 0) ? -quo_s : quo_s);
   assign oth_sat = sat32(other_w);
   assign s_sat   = sat32($signed(64'(dv.s)));
   assign d_re_in = (dv.p < 0) ? oth_sat.val : s_sat.val;
   assign d_im_in = (dv.p < 0) ? s_sat.val : oth_sat.val;

   always_comb begin
      fin_in     = dv;
      fin_in.ovf = dv.ovf | oth_sat.ovf | s_sat.ovf;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fin_ff  <= fin_in;
         d_re_ff <= d_re_in;
         d_im_ff <= d_im_in;
      end
   end

   // Roots c -/+ d, or the zero-b case
   assign r1r   = sat32(64'(fin_ff.c_re) - 64'(d_re_ff));
   assign r1i   = sat32(64'(fin_ff.c_im) - 64'(d_im_ff));
   assign r2r   = sat32(64'(fin_ff.c_re) + 64'(d_re_ff));
   assign r2i   = sat32(64'(fin_ff.c_im) + 64'(d_im_ff));
   assign na_re = sat32(-64'(fin_ff.a_re));
   assign na_im = sat32(-64'(fin_ff.a_im));

   always_comb begin
      if (fin_ff.b_zero) begin
         new_rsp.root1_re = '0;
         new_rsp.root1_im = '0;
         new_rsp.root2_re = na_re.val;
         new_rsp.root2_im = na_im.val;
         new_rsp.overflow = na_re.ovf | na_im.ovf;
      end else begin
         new_rsp.root1_re = r1r.val;
         new_rsp.root1_im = r1i.val;
         new_rsp.root2_re = r2r.val;
         new_rsp.root2_im = r2i.val;
         new_rsp.overflow = fin_ff.ovf | r1r.ovf | r1i.ovf | r2r.ovf | r2i.ovf;
      end
   end

   // Two-entry result queue; head is out0
   assign push      = en && valid_ff[6];
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = out0_ff;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (cnt_ff == 2'd2) begin
            out0_ff <= out1_ff;
         end else if (push) begin
            out0_ff <= new_rsp;
         end
      end else if (push) begin
         if (cnt_ff == 2'd0) begin
            out0_ff <= new_rsp;
         end else begin
            out1_ff <= new_rsp;
         end
      end
   end

endmodule

@@ design/cqs_checker.sv @@
module cqs_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input cqs_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input cqs_pkg::rsp_type rsp_data
);
   import cqs_pkg::*;

   // Reset leaves the queue empty and the input open
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("queue not empty after reset");

   // Input only closes when a result is waiting
   a_stall_has_rsp: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no result pending");

   // Queue fills only while a result sat untaken
   a_fill_cause: assert property (@(posedge clock) disable iff (reset)
      $fell(req_ready) |-> $past(rsp_valid && !rsp_ready))
      else $error("queue filled without a stalled result");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result changed while stalled");

endmodule

bind complex_quadratic_solver cqs_checker u_cqs_checker (.*);

@@ tb/sv/tb_complex_quadratic_solver.sv @@
module tb_complex_quadratic_solver;
   timeunit 1ns;
   timeprecision 1ps;

   import cqs_pkg::*;

   localparam int LATENCY   = 104 + FRAC_BITS;
   localparam int MAX_CYCLE = 400000;
   localparam logic signed [31:0] MOST_POS = 32'sh7fffffff;
   localparam logic signed [31:0] MOST_NEG = 32'sh80000000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rsp_type roots_due[$];
   int      mismatches = 0;
   int      cycle = 0;
   int      hold_off = 0;
   bit      stall_enable = 1'b1;

   complex_quadratic_solver dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > MAX_CYCLE) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Integer square root, rounding down
   function automatic logic [63:0] isqrt(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= r + bitv) begin
            v = v - (r + bitv);
            r = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
         bitv = bitv >> 2;
      end
      return r;
   endfunction

   function automatic longint clamp(input longint v, inout bit ovf);
      if (v > 64'sd2147483647) begin
         ovf = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         ovf = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // Arithmetic shift is a floor shift for signed values
   function automatic rsp_type solve_roots(input req_type r);
      rsp_type o;
      bit      ovf;
      longint  ar, ai, br, bi, cr, ci, pr, pi, dr, di, t, s, oth;
      logic [63:0] m, ap, aq;
      ovf = 1'b0;
      ar = r.coef_a_re;
      ai = r.coef_a_im;
      br = r.coef_b_re;
      bi = r.coef_b_im;
      if (br == 0 && bi == 0) begin
         o.root1_re = 0;
         o.root1_im = 0;
         o.root2_re = 32'(clamp(-ar, ovf));
         o.root2_im = 32'(clamp(-ai, ovf));
      end else begin
         cr = (-ar) >>> 1;
         ci = (-ai) >>> 1;
         pr = clamp(((cr * cr - ci * ci) >>> FRAC_BITS) - br, ovf);
         pi = clamp(((2 * cr * ci) >>> FRAC_BITS) - bi, ovf);
         if (pi != 0) begin
            ap = (pr < 0) ? -pr : pr;
            aq = (pi < 0) ? -pi : pi;
            m = isqrt(ap * ap + aq * aq);
            t = (pr < 0) ? longint'(m) - pr : longint'(m) + pr;
            s = isqrt(64'(t) << (FRAC_BITS - 1));
            oth = (s != 0) ? (pi * (64'sd1 << FRAC_BITS)) / (2 * s) : 0;
            if (pr < 0) begin
               dr = oth;
               di = s;
            end else begin
               dr = s;
               di = oth;
            end
         end else if (pr > 0) begin
            dr = isqrt(64'(pr) << FRAC_BITS);
            di = 0;
         end else if (pr < 0) begin
            dr = 0;
            di = isqrt(64'(-pr) << FRAC_BITS);
         end else begin
            dr = 0;
            di = 0;
         end
         dr = clamp(dr, ovf);
         di = clamp(di, ovf);
         o.root1_re = 32'(clamp(cr - dr, ovf));
         o.root1_im = 32'(clamp(ci - di, ovf));
         o.root2_re = 32'(clamp(cr + dr, ovf));
         o.root2_im = 32'(clamp(ci + di, ovf));
      end
      o.overflow = ovf;
      return o;
   endfunction

   // Receiver stall pattern, with a long hold-off on request
   always @(posedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= 1'b0;
      end else if (stall_enable) begin
         rsp_ready <= ((cycle % 37) < 30) && ($urandom_range(0, 3) != 0);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Result check against the oldest expected roots
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (roots_due.size() == 0) begin
            $error("unexpected result transfer");
            mismatches++;
         end else begin
            want = roots_due.pop_front();
            if (rsp_data.root1_re !== want.root1_re) begin
               $error("root1_re: expected %0d, got %0d", want.root1_re, rsp_data.root1_re);
               mismatches++;
            end
            if (rsp_data.root1_im !== want.root1_im) begin
               $error("root1_im: expected %0d, got %0d", want.root1_im, rsp_data.root1_im);
               mismatches++;
            end
            if (rsp_data.root2_re !== want.root2_re) begin
               $error("root2_re: expected %0d, got %0d", want.root2_re, rsp_data.root2_re);
               mismatches++;
            end
            if (rsp_data.root2_im !== want.root2_im) begin
               $error("root2_im: expected %0d, got %0d", want.root2_im, rsp_data.root2_im);
               mismatches++;
            end
            if (rsp_data.overflow !== want.overflow) begin
               $error("overflow: expected %0b, got %0b", want.overflow, rsp_data.overflow);
               mismatches++;
            end
         end
      end
   end

   // One input transfer; valid stays high into the next call without a drop
   task automatic send_coefs(input req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      roots_due.push_back(solve_roots(r));
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic pause_sender(input int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   function automatic req_type make_coefs(input logic [31:0] a_re, a_im, b_re, b_im);
      req_type r;
      r.coef_a_re = a_re;
      r.coef_a_im = a_im;
      r.coef_b_re = b_re;
      r.coef_b_im = b_im;
      return r;
   endfunction

   // Random value with a mix of magnitudes
   function automatic logic [31:0] rand_q();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
         2: return 32'($signed($urandom_range(0, 32'h3ffffff)) - 32'sh2000000);
         3: return ($urandom_range(0, 1)) ? MOST_POS : MOST_NEG;
         4: return 32'($signed($urandom_range(0, 32'h3fffffff)) - 32'sh20000000);
         default: return 32'($signed($urandom_range(0, 32'h7ff)) - 32'sh400);
      endcase
   endfunction

   // Extremes, zero b, real and imaginary discriminants, saturation
   task automatic test_directed();
      send_coefs(make_coefs(0, 0, 0, 0));
      send_coefs(make_coefs(MOST_NEG, MOST_NEG, 0, 0));
      send_coefs(make_coefs(MOST_POS, MOST_POS, 0, 0));
      send_coefs(make_coefs(32'h30000, 0, 32'h20000, 0));
      send_coefs(make_coefs(0, 0, 32'hfffc0000, 0));
      send_coefs(make_coefs(0, 0, 32'h40000, 0));
      send_coefs(make_coefs(0, 0, 0, 32'h10000));
      send_coefs(make_coefs(0, 0, 0, 32'hffff0000));
      send_coefs(make_coefs(32'h20000, 0, 32'h10000, 0));
      send_coefs(make_coefs(MOST_NEG, MOST_NEG, MOST_POS, MOST_NEG));
      send_coefs(make_coefs(MOST_POS, MOST_NEG, MOST_NEG, MOST_POS));
      send_coefs(make_coefs(MOST_POS, MOST_POS, MOST_POS, MOST_POS));
      send_coefs(make_coefs(MOST_NEG, MOST_POS, MOST_NEG, MOST_NEG));
      send_coefs(make_coefs(0, 0, MOST_NEG, MOST_NEG));
      send_coefs(make_coefs(0, 0, MOST_POS, 32'h1));
      send_coefs(make_coefs(32'h1, 32'hffffffff, 32'h1, 32'hffffffff));
      send_coefs(make_coefs(32'hffffffff, 32'h1, 32'h0, 32'h1));
      send_coefs(make_coefs(32'h10000, 32'h10000, 32'h10000, 32'hffff0000));
      pause_sender(1);
   endtask

   // Random coefficients in bursts with gaps
   task automatic test_random(input int count);
      int left;
      int burst;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 24);
         for (int i = 0; i < burst && left > 0; i++, left--) begin
            if ($urandom_range(0, 9) == 0)
               send_coefs(make_coefs(rand_q(), rand_q(), 0, 0));
            else
               send_coefs(make_coefs(rand_q(), rand_q(), rand_q(), rand_q()));
         end
         if ($urandom_range(0, 3) != 0)
            pause_sender($urandom_range(1, 9));
      end
      pause_sender(1);
   endtask

   // Receiver held off while the sender keeps offering, so the pipe fills
   task automatic test_backpressure();
      hold_off <= 3 * LATENCY;
      @(posedge clock);
      for (int i = 0; i < 300; i++)
         send_coefs(make_coefs(rand_q(), rand_q(), rand_q(), rand_q()));
      pause_sender(1);
   endtask

   // Full-rate stretch with no stalls on either side
   task automatic test_full_rate();
      stall_enable = 1'b0;
      for (int i = 0; i < 200; i++)
         send_coefs(make_coefs($urandom, $urandom, $urandom, $urandom));
      pause_sender(1);
      stall_enable = 1'b1;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(1000);
      test_backpressure();
      test_full_rate();
      wait (roots_due.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0 && roots_due.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
